FILE: rtl/core/enic_pkg.sv
// ----------------------------------------------------------------------------
// enic_pkg
// Shared types and constants of the expiring negative identifier cache.
// ----------------------------------------------------------------------------
package enic_pkg;

  localparam int unsigned IdentW     = 32;
  localparam int unsigned TickW      = 64;
  localparam int unsigned TtlW       = 32;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [TtlW-1:0] TtlReset = 32'd5000;

  localparam logic OpLookup = 1'b0;
  localparam logic OpInsert = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } enic_state_e;

  // classified request handed from the front to the back
  typedef struct packed {
    logic              op;
    logic              zero_id;
    logic [IdentW-1:0] ident;
    logic [TickW-1:0]  now;
    logic [TickW-1:0]  expiry;
  } cmd_t;

  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [TickW-1:0]  expiry;
  } entry_t;

  typedef struct packed {
    logic             cached;
    logic [SlotW-1:0] slot;
    logic             slot_used;
    logic             evicted;
  } res_t;

endpackage

FILE: rtl/core/enic_ram.sv
// ----------------------------------------------------------------------------
// enic_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module enic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/enic_fifo.sv
// ----------------------------------------------------------------------------
// enic_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module enic_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/enic_front.sv
// ----------------------------------------------------------------------------
// enic_front
// Request intake: holds the lifetime register, flags identifier zero and
// works out the expiry tick that an insert would write.
// ----------------------------------------------------------------------------
module enic_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       opcode_i,
  input  logic [enic_pkg::IdentW-1:0] ident_i,
  input  logic [enic_pkg::TickW-1:0] now_tick_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [enic_pkg::TtlW-1:0]  cfg_data_i,
  input  logic                       clearing_i,
  input  logic                       cmd_full_i,
  output logic                       cmd_push_o,
  output enic_pkg::cmd_t             cmd_o
);

  logic [enic_pkg::TtlW-1:0] ttl_q, ttl_d;

  assign cfg_ready_o = 1'b1;
  assign ttl_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= enic_pkg::TtlReset;
    end else begin
      ttl_q <= ttl_d;
    end
  end

  // no intake while the table is being cleared after reset
  assign full       = cmd_full_i || clearing_i;
  assign cmd_push_o = push && !full;

  always_comb begin
    cmd_o.op      = opcode_i;
    cmd_o.zero_id = (ident_i == '0);
    cmd_o.ident   = ident_i;
    cmd_o.now     = now_tick_i;
    // wraps at 64 bits
    cmd_o.expiry  = now_tick_i + {{(enic_pkg::TickW - enic_pkg::TtlW){1'b0}}, ttl_q};
  end

endmodule

FILE: rtl/core/enic_back.sv
// ----------------------------------------------------------------------------
// enic_back
// Table engine: clears the table after reset, then scans it one slot a
// cycle per nonzero-identifier request, tracking the earliest expiry for eviction.
// ----------------------------------------------------------------------------
module enic_back #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  enic_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output enic_pkg::res_t res_o,
  output logic           clearing_o
);

  localparam int unsigned IW     = $clog2(ENTRIES);
  localparam int unsigned EntryW = $bits(enic_pkg::entry_t);

  enic_pkg::enic_state_e state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d, victim_q, victim_d;
  logic [enic_pkg::TickW-1:0] best_q, best_d;
  enic_pkg::cmd_t        cmd_q, cmd_d;
  enic_pkg::res_t        res_q, res_d;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [EntryW-1:0]     ram_wdata, ram_rdata;
  enic_pkg::entry_t      ent, wr_ent;

  logic last, id_hit, expired, ins_qual, take_cur, scan_done;
  logic [IW-1:0] vict_idx;

  function automatic logic [enic_pkg::SlotW-1:0] slot_of(input logic [IW-1:0] i);
    logic [IW+enic_pkg::SlotW-1:0] wide;
    wide = {{enic_pkg::SlotW{1'b0}}, i};
    return wide[enic_pkg::SlotW-1:0];
  endfunction

  enic_ram #(
    .WIDTH (EntryW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // read data always belongs to slot idx_q while scanning
  assign ent       = enic_pkg::entry_t'(ram_rdata);
  assign last      = (idx_q == IW'(ENTRIES - 1));
  assign id_hit    = (ent.ident == cmd_q.ident);
  assign expired   = (ent.expiry < cmd_q.now);
  assign ins_qual  = id_hit || (ent.ident == '0) || expired;
  assign take_cur  = (idx_q == '0) || (ent.expiry < best_q);
  assign vict_idx  = take_cur ? idx_q : victim_q;
  assign scan_done = last || ((cmd_q.op == enic_pkg::OpLookup) ? id_hit : ins_qual);

  assign clearing_o = (state_q == enic_pkg::ST_CLEAR);
  assign res_o      = res_q;
  assign ram_wdata  = wr_ent;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      enic_pkg::ST_CLEAR: begin
        if (last) state_d = enic_pkg::ST_IDLE;
      end
      enic_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = cmd_i.zero_id ? enic_pkg::ST_EMIT : enic_pkg::ST_SCAN;
        end
      end
      enic_pkg::ST_SCAN: begin
        if (scan_done) state_d = enic_pkg::ST_EMIT;
      end
      enic_pkg::ST_EMIT: begin
        if (!res_full_i) state_d = enic_pkg::ST_IDLE;
      end
      default: state_d = enic_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    idx_d      = idx_q;
    victim_d   = victim_q;
    best_d     = best_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_raddr  = idx_q;
    wr_ent     = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      enic_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        idx_d  = last ? '0 : idx_q + IW'(1);
      end
      enic_pkg::ST_IDLE: begin
        ram_raddr = '0;
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          res_d     = '0;
        end
      end
      enic_pkg::ST_SCAN: begin
        ram_raddr = last ? idx_q : idx_q + IW'(1);
        idx_d     = last ? '0 : idx_q + IW'(1);
        if (take_cur) begin
          best_d   = ent.expiry;
          victim_d = idx_q;
        end
        if (cmd_q.op == enic_pkg::OpLookup) begin
          if (id_hit) begin
            res_d.slot      = slot_of(idx_q);
            res_d.slot_used = 1'b1;
            if (expired) begin
              // drop the identifier, keep the expiry
              ram_we        = 1'b1;
              wr_ent.expiry = ent.expiry;
            end else begin
              res_d.cached = 1'b1;
            end
          end
        end else begin
          wr_ent.ident  = cmd_q.ident;
          wr_ent.expiry = cmd_q.expiry;
          if (ins_qual) begin
            ram_we          = 1'b1;
            res_d.slot      = slot_of(idx_q);
            res_d.slot_used = 1'b1;
          end else if (last) begin
            ram_we          = 1'b1;
            ram_waddr       = vict_idx;
            res_d.slot      = slot_of(vict_idx);
            res_d.slot_used = 1'b1;
            res_d.evicted   = 1'b1;
          end
        end
      end
      enic_pkg::ST_EMIT: begin
        res_push_o = !res_full_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= enic_pkg::ST_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    victim_q <= victim_d;
    best_q   <= best_d;
    cmd_q    <= cmd_d;
    res_q    <= res_d;
  end

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == enic_pkg::ST_IDLE)
    else $error("command taken outside idle");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == enic_pkg::ST_CLEAR || state_q == enic_pkg::ST_SCAN))
    else $error("table written outside clear or scan");

  a_evict_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.evicted) |-> (res_o.slot_used && !res_o.cached))
    else $error("eviction result malformed");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(ENTRIES - 1))
    else $error("scan index out of range");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == enic_pkg::ST_SCAN && last) |=> state_q == enic_pkg::ST_EMIT)
    else $error("scan ran past the last slot");

endmodule

FILE: rtl/core/expiring_negative_id_cache_top.sv
// ----------------------------------------------------------------------------
// expiring_negative_id_cache_top
// Table of identifiers with expiry ticks; lookups report live entries,
// inserts fill a free, matching or expired slot or evict the earliest.
//
// channel   direction  handshake                  payload
// request   in         push / full                opcode_i, ident_i, now_tick_i
// result    out        empty / pop                cached_o, slot_o, slot_used_o, evicted_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (ttl ticks)
//
// a request with nonzero identifier scans k slots (at most ENTRIES) before
// its result enters the result queue; the table RAM read port is walked
// one slot per cycle. identifier zero skips the scan.
// after reset the table is cleared one slot per cycle through all ENTRIES
// slots, during which full stays high.
// two-deep queues sit between intake and engine and on the result side.
// ----------------------------------------------------------------------------
module expiring_negative_id_cache_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        opcode_i,
  input  logic [enic_pkg::IdentW-1:0] ident_i,
  input  logic [enic_pkg::TickW-1:0]  now_tick_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        cached_o,
  output logic [enic_pkg::SlotW-1:0]  slot_o,
  output logic                        slot_used_o,
  output logic                        evicted_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [enic_pkg::TtlW-1:0]   cfg_data_i
);

  localparam int unsigned CmdW = $bits(enic_pkg::cmd_t);
  localparam int unsigned ResW = $bits(enic_pkg::res_t);

  enic_pkg::cmd_t cmd_in, cmd_out;
  enic_pkg::res_t res_in, res_out;
  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic           res_push, res_full, clearing;
  logic [CmdW-1:0] cmd_out_bits;
  logic [ResW-1:0] res_out_bits;

  enic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .ident_i     (ident_i),
    .now_tick_i  (now_tick_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .clearing_i  (clearing),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  enic_fifo #(
    .WIDTH (CmdW),
    .DEPTH (enic_pkg::QueueDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out_bits),
    .empty_o (cmd_empty)
  );

  assign cmd_out = enic_pkg::cmd_t'(cmd_out_bits);

  enic_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  enic_fifo #(
    .WIDTH (ResW),
    .DEPTH (enic_pkg::QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .empty_o (empty)
  );

  assign res_out     = enic_pkg::res_t'(res_out_bits);
  assign cached_o    = res_out.cached;
  assign slot_o      = res_out.slot;
  assign slot_used_o = res_out.slot_used;
  assign evicted_o   = res_out.evicted;

endmodule

FILE: test/enic_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// enic_checker
// Watches the request, result and config channels of the expiring negative
// identifier cache, keeps its own copy of the table, predicts one result per
// accepted request and compares every popped result against the oldest one.
// ----------------------------------------------------------------------------
module enic_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic                        opcode_i,
  input  logic [enic_pkg::IdentW-1:0] ident_i,
  input  logic [enic_pkg::TickW-1:0]  now_tick_i,
  input  logic                        empty_i,
  input  logic                        pop_i,
  input  logic                        cached_i,
  input  logic [enic_pkg::SlotW-1:0]  slot_i,
  input  logic                        slot_used_i,
  input  logic                        evicted_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [enic_pkg::TtlW-1:0]   cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 outstanding_o,
  output int unsigned                 n_results_o,
  output int unsigned                 n_hits_o,
  output int unsigned                 n_expired_o,
  output int unsigned                 n_evicts_o
);

  logic [enic_pkg::IdentW-1:0] tab_ident  [ENTRIES];
  logic [enic_pkg::TickW-1:0]  tab_expiry [ENTRIES];
  logic [enic_pkg::TtlW-1:0]   tab_ttl;

  enic_pkg::res_t want_q [$];
  enic_pkg::res_t want;
  enic_pkg::res_t got;
  int unsigned    fails;
  int unsigned    n_results;
  int unsigned    n_hits;
  int unsigned    n_expired;
  int unsigned    n_evicts;

  // table walk of one request, updates the local table copy
  function automatic enic_pkg::res_t cache_access(logic op,
                                                  logic [enic_pkg::IdentW-1:0] id,
                                                  logic [enic_pkg::TickW-1:0] now);
    enic_pkg::res_t             r;
    int                         victim;
    logic [enic_pkg::TickW-1:0] best;
    logic [enic_pkg::TickW-1:0] ttl_wide;
    r        = '0;
    ttl_wide = {{(enic_pkg::TickW - enic_pkg::TtlW){1'b0}}, tab_ttl};
    if (id == '0) begin
      return r;
    end
    if (op == enic_pkg::OpLookup) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (tab_ident[k] == id) begin
          if (tab_expiry[k] >= now) begin
            r.cached = 1'b1;
          end else begin
            tab_ident[k] = '0;  // expiry is kept
          end
          r.slot      = enic_pkg::SlotW'(k);
          r.slot_used = 1'b1;
          return r;
        end
      end
      return r;
    end
    r.slot_used = 1'b1;
    for (int k = 0; k < ENTRIES; k++) begin
      if (tab_ident[k] == id || tab_ident[k] == '0 || tab_expiry[k] < now) begin
        tab_ident[k]  = id;
        tab_expiry[k] = now + ttl_wide;
        r.slot        = enic_pkg::SlotW'(k);
        return r;
      end
    end
    // table full of live entries: earliest expiry goes, lowest index on a tie
    victim = 0;
    best   = tab_expiry[0];
    for (int k = 1; k < ENTRIES; k++) begin
      if (tab_expiry[k] < best) begin
        best   = tab_expiry[k];
        victim = k;
      end
    end
    tab_ident[victim]  = id;
    tab_expiry[victim] = now + ttl_wide;
    r.slot             = enic_pkg::SlotW'(victim);
    r.evicted          = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        tab_ident[k]  = '0;
        tab_expiry[k] = '0;
      end
      tab_ttl   = enic_pkg::TtlReset;
      want_q.delete();
      fails     = 0;
      n_results = 0;
      n_hits    = 0;
      n_expired = 0;
      n_evicts  = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        tab_ttl = cfg_data_i;
      end
      if (pop_i && !empty_i) begin
        got.cached    = cached_i;
        got.slot      = slot_i;
        got.slot_used = slot_used_i;
        got.evicted   = evicted_i;
        n_results++;
        if (want_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("[%0t] result transfer with nothing outstanding: cached=%0b slot=%0d "
                     , $time, got.cached, got.slot,
                     "used=%0b evicted=%0b", got.slot_used, got.evicted);
          end
        end else begin
          want = want_q.pop_front();
          if (got.cached !== want.cached || got.slot !== want.slot ||
              got.slot_used !== want.slot_used || got.evicted !== want.evicted) begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] mismatch: expected cached=%0b slot=%0d used=%0b evicted=%0b",
                       $time, want.cached, want.slot, want.slot_used, want.evicted);
              $display("[%0t]           actual   cached=%0b slot=%0d used=%0b evicted=%0b",
                       $time, got.cached, got.slot, got.slot_used, got.evicted);
            end
          end
        end
      end
      if (push_i && !full_i) begin
        want = cache_access(opcode_i, ident_i, now_tick_i);
        if (want.cached) n_hits++;
        if (want.evicted) n_evicts++;
        if (opcode_i == enic_pkg::OpLookup && want.slot_used && !want.cached) n_expired++;
        want_q.push_back(want);
      end
      outstanding_o <= want_q.size();
    end
    fail_count_o <= fails;
    n_results_o  <= n_results;
    n_hits_o     <= n_hits;
    n_expired_o  <= n_expired;
    n_evicts_o   <= n_evicts;
  end

endmodule

FILE: test/tb_expiring_negative_id_cache_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expiring_negative_id_cache_top
// Drives lookups and inserts into the identifier cache under several ttl
// settings and idle patterns; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_expiring_negative_id_cache_top;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned N_PHASES   = 8;
  localparam int unsigned PHASE_REQS = 210;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        push        = 1'b0;
  logic                        full;
  logic                        opcode_i    = enic_pkg::OpLookup;
  logic [enic_pkg::IdentW-1:0] ident_i     = '0;
  logic [enic_pkg::TickW-1:0]  now_tick_i  = '0;
  logic                        empty;
  logic                        pop         = 1'b0;
  logic                        cached_o;
  logic [enic_pkg::SlotW-1:0]  slot_o;
  logic                        slot_used_o;
  logic                        evicted_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [enic_pkg::TtlW-1:0]   cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned n_results;
  int unsigned n_hits;
  int unsigned n_expired;
  int unsigned n_evicts;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_sent       = 0;
  int unsigned n_ttl_writes = 0;
  int unsigned idle_cycles  = 0;

  logic [enic_pkg::IdentW-1:0] id_pool [256];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  expiring_negative_id_cache_top #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .ident_i     (ident_i),
    .now_tick_i  (now_tick_i),
    .empty       (empty),
    .pop         (pop),
    .cached_o    (cached_o),
    .slot_o      (slot_o),
    .slot_used_o (slot_used_o),
    .evicted_o   (evicted_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  enic_checker #(
    .ENTRIES (ENTRIES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .opcode_i      (opcode_i),
    .ident_i       (ident_i),
    .now_tick_i    (now_tick_i),
    .empty_i       (empty),
    .pop_i         (pop),
    .cached_i      (cached_o),
    .slot_i        (slot_o),
    .slot_used_i   (slot_used_o),
    .evicted_i     (evicted_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .n_results_o   (n_results),
    .n_hits_o      (n_hits),
    .n_expired_o   (n_expired),
    .n_evicts_o    (n_evicts)
  );

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_req(input logic op, input logic [enic_pkg::IdentW-1:0] id,
                          input logic [enic_pkg::TickW-1:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    opcode_i   <= op;
    ident_i    <= id;
    now_tick_i <= now;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_sent++;
  endtask

  // stop sending and wait until every predicted result has been popped
  task automatic drain;
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_ttl(input logic [enic_pkg::TtlW-1:0] ttl);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ttl;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_ttl_writes++;
  endtask

  function automatic logic [enic_pkg::TickW-1:0] rand_tick();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [enic_pkg::TickW-1:0]  cur_tick;
    logic [enic_pkg::TtlW-1:0]   ttl;
    logic [enic_pkg::IdentW-1:0] id;
    logic                        op;
    int unsigned                 pool_n;
    int unsigned                 step_max;
    int unsigned                 roll;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset ttl: zero identifier, miss, live on the expiry tick, expired lookup
    send_req(enic_pkg::OpLookup, '0, rand_tick());
    send_req(enic_pkg::OpInsert, '0, '1);
    send_req(enic_pkg::OpLookup, '1, 64'd100);
    send_req(enic_pkg::OpInsert, '1, 64'd100);
    send_req(enic_pkg::OpLookup, '1, 64'd5100);
    send_req(enic_pkg::OpLookup, '1, 64'd5101);
    send_req(enic_pkg::OpLookup, '1, 64'd5101);
    send_req(enic_pkg::OpInsert, 32'd1, '0);
    send_req(enic_pkg::OpInsert, 32'd1, 64'd10);
    // expired slot reused, expiry wraps past the top of the tick range
    send_req(enic_pkg::OpInsert, 32'd2, '1);
    send_req(enic_pkg::OpInsert, 32'd3, '1);
    send_req(enic_pkg::OpLookup, 32'd2, '1);

    write_ttl('0);
    send_req(enic_pkg::OpInsert, 32'd5, 64'd50);
    send_req(enic_pkg::OpLookup, 32'd5, 64'd50);
    send_req(enic_pkg::OpLookup, 32'd5, 64'd51);

    write_ttl('1);
    send_req(enic_pkg::OpInsert, 32'd7, 64'hFFFF_FFFF_0000_0000);
    send_req(enic_pkg::OpLookup, 32'd7, '1);
    send_req(enic_pkg::OpInsert, 32'd8, '1);
    send_req(enic_pkg::OpLookup, 32'd8, 64'hFFFF_FFFF);
    send_req(enic_pkg::OpLookup, 32'd8, 64'h1_0000_0000);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          ttl = enic_pkg::TtlReset; pool_n = 80; step_max = 20; cur_tick = 64'd0;
        end
        1: begin ttl = '0;           pool_n = 12;  step_max = 2;    cur_tick = rand_tick(); end
        2: begin ttl = '1;           pool_n = 100; step_max = 1000; cur_tick = rand_tick(); end
        3: begin ttl = 32'd20;       pool_n = 40;  step_max = 3;    cur_tick = '1 - 64'd300; end
        4: begin ttl = 32'd300;      pool_n = 90;  step_max = 2;    cur_tick = rand_tick(); end
        5: begin ttl = $urandom();   pool_n = 200; step_max = 50;   cur_tick = rand_tick(); end
        6: begin ttl = 32'd1;        pool_n = 8;   step_max = 1;    cur_tick = rand_tick(); end
        default: begin
          ttl = enic_pkg::TtlReset; pool_n = 70; step_max = 10; cur_tick = rand_tick();
        end
      endcase
      write_ttl(ttl);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      for (int k = 0; k < pool_n; k++) begin
        id_pool[k] = $urandom();
        if (id_pool[k] == '0) id_pool[k] = 32'h8000_0001;
      end

      for (int n = 0; n < PHASE_REQS; n++) begin
        roll = $urandom_range(99);
        op   = 1'($urandom_range(1));
        id   = id_pool[$urandom_range(pool_n - 1)];
        if (roll < 4) begin
          send_req(op, '0, rand_tick());
        end else if (roll < 8) begin
          send_req(op, $urandom(), cur_tick);
        end else if (roll < 10) begin
          send_req(op, id, rand_tick());
        end else begin
          send_req(op, id, cur_tick);
        end
        cur_tick = cur_tick + 64'($urandom_range(step_max));
        // sender holds off until the pipeline is empty
        if (n == PHASE_REQS / 2 || $urandom_range(199) == 0) begin
          drain();
        end
      end
      drain();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    drain();
    repeat (2 * ENTRIES + 16) @(posedge clk_i);

    $display("covered %0d requests under %0d ttl writes, %0d results checked",
             n_sent, n_ttl_writes, n_results);
    $display("live hits %0d, expired lookups %0d, evictions %0d",
             n_hits, n_expired, n_evicts);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, outstanding);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/enic_pkg.sv
rtl/core/enic_ram.sv
rtl/core/enic_fifo.sv
rtl/core/enic_front.sv
rtl/core/enic_back.sv
rtl/core/expiring_negative_id_cache_top.sv
test/enic_checker.sv
test/tb_expiring_negative_id_cache_top.sv
